>>> hw/rtl/sorted_key_table_unit_macros.svh
// Assertion macros shared by the sorted key table RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef SORTED_KEY_TABLE_UNIT_MACROS_SVH
`define SORTED_KEY_TABLE_UNIT_MACROS_SVH

// Same-cycle implication.
`define SKT_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication.
`define SKT_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> hw/rtl/skt_pkg.sv
package skt_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int KEY_W        = 32;
  localparam int VALUE_W      = 32;
  localparam int OCC_W        = 6;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic                      opcode;
    logic signed [KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] entry_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [OCC_W-1:0]          occupancy;
  } res_t;

  typedef struct packed {
    logic                      valid;
    logic signed [KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/skt_cell.sv
module skt_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  skt_pkg::cell_ctrl_t               ctrl,
  input  logic signed [skt_pkg::KEY_W-1:0]  cmd_key,
  input  logic signed [skt_pkg::VALUE_W-1:0] cmd_value,
  input  skt_pkg::entry_t                   left_entry,
  input  logic                              left_ge,
  input  skt_pkg::entry_t                   right_entry,
  output skt_pkg::entry_t                   entry,
  output logic                              ge,
  output logic                              eq
);
  import skt_pkg::*;

  logic                      valid;
  logic signed [KEY_W-1:0]   key;
  logic signed [VALUE_W-1:0] value;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins && ge) begin
      valid <= left_ge ? left_entry.valid : 1'b1;
    end else if (ctrl.del && ge) begin
      valid <= right_entry.valid;
    end
  end

  // Insert: the first cell at or above the key takes the new word, the rest shift up.
  // Delete: every cell from the hit onward pulls from its right neighbor.
  always_ff @(posedge clk) begin
    if (ctrl.ins && ge) begin
      key   <= left_ge ? left_entry.key   : cmd_key;
      value <= left_ge ? left_entry.value : cmd_value;
    end else if (ctrl.del && ge) begin
      key   <= right_entry.key;
      value <= right_entry.value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      ge <= !(valid && (key < cmd_key));
      eq <= valid && (key == cmd_key);
    end
  end

  assign entry = '{valid: valid, key: key, value: value};

endmodule

>>> hw/rtl/sorted_key_table_unit.sv
// Sorted key/value table of CAPACITY entries held in a chain of cells, kept in ascending
// signed key order. Each command word is an insert or a delete and yields one result
// word with status, removed value and occupancy. A command passes through accept,
// a parallel compare in every cell, then an apply step in which each cell loads from
// itself, its left or its right neighbor. The apply step waits while an earlier result
// word is still not taken. No clearing pass is needed after reset.
`include "sorted_key_table_unit_macros.svh"

module sorted_key_table_unit #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  skt_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output skt_pkg::res_t res
);
  import skt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t                state, state_next;
  cmd_t                  cur;
  logic [CNT_W-1:0]      count;
  cell_ctrl_t            ctrl;
  entry_t                cell_entry [CAPACITY];
  entry_t                left_in    [CAPACITY];
  entry_t                right_in   [CAPACITY];
  logic [CAPACITY-1:0]   ge_vec;
  logic [CAPACITY-1:0]   eq_vec;
  logic [CAPACITY-1:0]   left_ge;
  logic [CAPACITY-1:0]   valid_vec;
  logic                  hit;
  logic signed [VALUE_W-1:0] hit_value;
  logic                  full;
  logic                  fire;
  logic [1:0]            status;

  assign cmd_ready = (state == S_IDLE);
  assign full      = (count == CNT_W'(CAPACITY));
  assign fire      = (state == S_APPLY) && (!res_valid || res_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (cmd_valid) state_next = S_CMP;
      S_CMP:   state_next = S_APPLY;
      S_APPLY: if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cur <= cmd;
    end
  end

  // Pick out the hit cell; at most one cell matches since keys are unique.
  always_comb begin
    hit       = 1'b0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit       = hit | eq_vec[i];
      hit_value = hit_value | (eq_vec[i] ? cell_entry[i].value : '0);
    end
  end

  always_comb begin
    ctrl.cmp = (state == S_CMP);
    ctrl.ins = 1'b0;
    ctrl.del = 1'b0;
    if (cur.opcode == OP_INSERT) begin
      if (hit) begin
        status = ST_DUP;
      end else if (full) begin
        status = ST_FULL;
      end else begin
        status   = ST_OK;
        ctrl.ins = fire;
      end
    end else begin
      if (hit) begin
        status   = ST_OK;
        ctrl.del = fire;
      end else begin
        status = ST_MISSING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.ins) begin
      count <= count + 1'b1;
    end else if (ctrl.del) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.status        <= status;
      res.removed_value <= ((cur.opcode == OP_DELETE) && hit) ? hit_value : '0;
      if (ctrl.ins) begin
        res.occupancy <= OCC_W'(count + 1'b1);
      end else if (ctrl.del) begin
        res.occupancy <= OCC_W'(count - 1'b1);
      end else begin
        res.occupancy <= OCC_W'(count);
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_in[i] = '0;
      assign left_ge[i] = 1'b0;
    end else begin : g_mid
      assign left_in[i] = cell_entry[i-1];
      assign left_ge[i] = ge_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in[i] = '0;
    end else begin : g_inner
      assign right_in[i] = cell_entry[i+1];
    end
    assign valid_vec[i] = cell_entry[i].valid;

    skt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .cmd_key     (cur.key),
      .cmd_value   (cur.entry_value),
      .left_entry  (left_in[i]),
      .left_ge     (left_ge[i]),
      .right_entry (right_in[i]),
      .entry       (cell_entry[i]),
      .ge          (ge_vec[i]),
      .eq          (eq_vec[i])
    );
  end

  `SKT_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "entry count above capacity")
  `SKT_ASSERT_NOW(a_count_match, 1'b1, $countones(valid_vec) == int'(count), "valid cells disagree with count")
  `SKT_ASSERT_NOW(a_single_hit, state == S_APPLY, $onehot0(eq_vec), "more than one cell matches key")
  `SKT_ASSERT_NOW(a_ge_monotonic, state == S_APPLY, ((ge_vec << 1) & ~ge_vec) == '0, "ge out of order")

endmodule
